/* rtl/core/ihex_pkg.sv */
// ----------------------------------------------------------------------------
// ihex_pkg
// Types and constants shared by the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_COUNT = 3'd1,
		PH_ADDR  = 3'd2,
		PH_TYPE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CSUM  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		K_DATA     = 3'd0,
		K_OK       = 3'd1,
		K_BADSUM   = 3'd2,
		K_BADUPPER = 3'd3,
		K_EOF      = 3'd4
	} kind_t;

	localparam logic [7:0] RT_DATA  = 8'h00;
	localparam logic [7:0] RT_EOF   = 8'h01;
	localparam logic [7:0] RT_UPPER = 8'h04;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	// classified character, front to back
	typedef struct packed {
		logic       new_file;
		logic       colon;
		logic       newline;
		logic [3:0] nib;
	} tok_t;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = 4'(c[3:0] + 4'd9);
		end
		return v;
	endfunction

endpackage

/* rtl/core/ihex_if.sv */
// ----------------------------------------------------------------------------
// ihex_if
// Valid/ready channels: text characters in, parse results out.
// ----------------------------------------------------------------------------
interface ihex_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_in;

	modport source (output valid, opcode, char_in, input ready);
	modport sink   (input valid, opcode, char_in, output ready);
endinterface

interface ihex_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic        region;
	logic [15:0] address;
	logic [7:0]  data_byte;
	logic [7:0]  record_type;
	logic [7:0]  byte_count;

	modport source (output valid, kind, region, address, data_byte, record_type,
		byte_count, input ready);
	modport sink   (input valid, kind, region, address, data_byte, record_type,
		byte_count, output ready);
endinterface

/* rtl/core/intel_hex_record_parser.sv */
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Streaming Intel HEX record parser: characters in, data bytes and record
// verdicts out.
//
//   channel  dir  payload                                        handshake
//   text     in   opcode, char_in                                valid/ready
//   result   out  kind, region, address, data_byte,              valid/ready
//                 record_type, byte_count
//   cfg      in   cfg_wdata (first_file)                         cfg_we
//
// One character per cycle sustained unless stalled. A character enters the
// classifier queue (QUEUE_DEPTH entries) and is parsed once it leaves; a
// result is registered and appears the cycle after its character is parsed.
// The parser stalls only while an unread result sits in the output register;
// the queue then fills and text.ready drops. Reset clears all control state.
// ----------------------------------------------------------------------------
module intel_hex_record_parser
	import ihex_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	ihex_in_if.sink     text,
	ihex_out_if.source  result
);

	tok_t tok;
	logic tok_valid;
	logic tok_ready;
	logic first_file_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_file_q <= 1'b1;
		end else if (cfg_we) begin
			first_file_q <= cfg_wdata;
		end
	end

	ihex_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.tok       (tok),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready)
	);

	ihex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.first_file (first_file_q),
		.tok        (tok),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.result     (result)
	);

endmodule

/* rtl/core/ihex_front.sv */
// ----------------------------------------------------------------------------
// ihex_front
// Classifies incoming characters and queues them for the parser.
// ----------------------------------------------------------------------------
module ihex_front
	import ihex_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	ihex_in_if.sink text,
	output tok_t   tok,
	output logic   tok_valid,
	input  logic   tok_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	tok_t             queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	tok_t             tok_in;
	logic             push;
	logic             pop;

	assign tok_in.new_file = text.opcode;
	assign tok_in.colon    = (text.char_in == CHAR_COLON);
	assign tok_in.newline  = (text.char_in == CHAR_LF);
	assign tok_in.nib      = hex_nibble(text.char_in);

	assign text.ready = (count_q != CNT_FULL);
	assign push       = text.valid && text.ready;
	assign tok_valid  = (count_q != '0);
	assign pop        = tok_valid && tok_ready;
	assign tok        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

/* rtl/core/ihex_back.sv */
// ----------------------------------------------------------------------------
// ihex_back
// Record parser: field collection, checksum, region tracking, result register.
// ----------------------------------------------------------------------------
module ihex_back
	import ihex_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        first_file,
	input  tok_t        tok,
	input  logic        tok_valid,
	output logic        tok_ready,
	ihex_out_if.source  result
);

	phase_t      phase_q, phase_d;
	logic        nib_high_q, nib_high_d;
	logic [3:0]  hi_nib_q, hi_nib_d;
	logic [7:0]  field_pos_q, field_pos_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  rec_count_q, rec_count_d;
	logic [15:0] rec_address_q, rec_address_d;
	logic [7:0]  rec_type_q, rec_type_d;
	logic [15:0] pending_q, pending_d;
	logic        region_q, region_d;
	logic        file_done_q, file_done_d;

	logic        out_valid_q;
	kind_t       kind_q;
	logic        region_out_q;
	logic [15:0] address_q;
	logic [7:0]  data_q;
	logic [7:0]  rtype_q;
	logic [7:0]  bcount_q;

	logic        pop;
	logic        take;
	logic [7:0]  b;
	logic [7:0]  sum_b;
	logic [7:0]  pos_next;
	logic        emit;
	kind_t       emit_kind;
	logic [15:0] emit_addr;
	logic [7:0]  emit_data;

	assign tok_ready = !out_valid_q || result.ready;
	assign pop       = tok_valid && tok_ready;
	// second nibble of a byte inside a live record
	assign take      = pop && !tok.new_file && !file_done_q && (phase_q != PH_IDLE)
		&& !tok.newline && nib_high_q;
	assign b         = {hi_nib_q, tok.nib};
	assign sum_b     = 8'(sum_q + b);
	assign pos_next  = 8'(field_pos_q + 1'b1);

	// next parse phase
	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			if (tok.new_file) begin
				phase_d = PH_IDLE;
			end else if (!file_done_q) begin
				if (phase_q == PH_IDLE) begin
					if (tok.colon) begin
						phase_d = PH_COUNT;
					end
				end else if (tok.newline) begin
					phase_d = PH_IDLE;
				end else if (nib_high_q) begin
					case (phase_q)
						PH_COUNT: phase_d = PH_ADDR;
						PH_ADDR:  phase_d = (field_pos_q != 8'd0) ? PH_TYPE : PH_ADDR;
						PH_TYPE:  phase_d = (rec_count_q != 8'd0) ? PH_DATA : PH_CSUM;
						PH_DATA:  phase_d = (pos_next >= rec_count_q) ? PH_CSUM : PH_DATA;
						default:  phase_d = PH_IDLE;
					endcase
				end
			end
		end
	end

	// record fields and results
	always_comb begin
		nib_high_d    = nib_high_q;
		hi_nib_d      = hi_nib_q;
		field_pos_d   = field_pos_q;
		sum_d         = sum_q;
		rec_count_d   = rec_count_q;
		rec_address_d = rec_address_q;
		rec_type_d    = rec_type_q;
		pending_d     = pending_q;
		region_d      = region_q;
		file_done_d   = file_done_q;
		emit          = 1'b0;
		emit_kind     = K_OK;
		emit_addr     = rec_address_q;
		emit_data     = 8'd0;

		if (pop && (tok.new_file || (!file_done_q && phase_q == PH_IDLE && tok.colon))) begin
			nib_high_d    = 1'b0;
			hi_nib_d      = 4'd0;
			field_pos_d   = 8'd0;
			sum_d         = 8'd0;
			rec_count_d   = 8'd0;
			rec_address_d = 16'd0;
			rec_type_d    = 8'd0;
			pending_d     = 16'd0;
			if (tok.new_file) begin
				region_d    = 1'b0;
				file_done_d = 1'b0;
			end
		end else if (pop && !file_done_q && phase_q != PH_IDLE) begin
			if (tok.newline) begin
				emit      = 1'b1;
				emit_kind = K_BADSUM;
			end else if (!nib_high_q) begin
				hi_nib_d   = tok.nib;
				nib_high_d = 1'b1;
			end
		end

		if (take) begin
			nib_high_d = 1'b0;
			case (phase_q)
				PH_COUNT: begin
					rec_count_d = b;
					sum_d       = sum_b;
					field_pos_d = 8'd0;
				end
				PH_ADDR: begin
					rec_address_d = {rec_address_q[7:0], b};
					sum_d         = sum_b;
					field_pos_d   = (field_pos_q != 8'd0) ? 8'd0 : pos_next;
				end
				PH_TYPE: begin
					rec_type_d  = b;
					sum_d       = sum_b;
					field_pos_d = 8'd0;
				end
				PH_DATA: begin
					sum_d       = sum_b;
					field_pos_d = pos_next;
					if (field_pos_q == 8'd0) begin
						pending_d = {b, 8'd0};
					end else if (field_pos_q == 8'd1) begin
						pending_d = {pending_q[15:8], b};
					end
					if (rec_type_q == RT_DATA && (first_file || !region_q)) begin
						emit      = 1'b1;
						emit_kind = K_DATA;
						emit_addr = 16'(rec_address_q + {8'd0, field_pos_q});
						emit_data = b;
					end
				end
				PH_CSUM: begin
					emit = 1'b1;
					if (sum_b != 8'd0) begin
						emit_kind = K_BADSUM;
					end else if (rec_type_q == RT_UPPER) begin
						if (pending_q[15:1] != 15'd0) begin
							emit_kind = K_BADUPPER;
						end else begin
							region_d  = pending_q[0];
							emit_kind = K_OK;
						end
					end else if (rec_type_q == RT_EOF) begin
						file_done_d = 1'b1;
						emit_kind   = K_EOF;
					end else begin
						emit_kind = K_OK;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			nib_high_q    <= 1'b0;
			hi_nib_q      <= 4'd0;
			field_pos_q   <= 8'd0;
			sum_q         <= 8'd0;
			rec_count_q   <= 8'd0;
			rec_address_q <= 16'd0;
			rec_type_q    <= 8'd0;
			pending_q     <= 16'd0;
			region_q      <= 1'b0;
			file_done_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			nib_high_q    <= nib_high_d;
			hi_nib_q      <= hi_nib_d;
			field_pos_q   <= field_pos_d;
			sum_q         <= sum_d;
			rec_count_q   <= rec_count_d;
			rec_address_q <= rec_address_d;
			rec_type_q    <= rec_type_d;
			pending_q     <= pending_d;
			region_q      <= region_d;
			file_done_q   <= file_done_d;
			if (pop) begin
				out_valid_q <= emit;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q       <= emit_kind;
			region_out_q <= region_d;
			address_q    <= emit_addr;
			data_q       <= emit_data;
			rtype_q      <= rec_type_d;
			bcount_q     <= rec_count_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.kind        = kind_q;
	assign result.region      = region_out_q;
	assign result.address     = address_q;
	assign result.data_byte   = data_q;
	assign result.record_type = rtype_q;
	assign result.byte_count  = bcount_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for intel_hex_record_parser. Hex text is built record by record,
// mostly well formed with random content, plus bad checksums, cut-off lines,
// end-of-file and new-file steps and stray characters. A behavioural parser
// in the bench predicts each result; results are compared in order, field by
// field, under random gaps on the text side and random stalls on the result
// side. first_file is switched between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb;
	import ihex_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 20;

	localparam int REC_GOOD   = 0;
	localparam int REC_BADSUM = 1;
	localparam int REC_SHORT  = 2;

	typedef struct packed {
		kind_t       kind;
		logic        region;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic [7:0]  record_type;
		logic [7:0]  byte_count;
	} parse_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ihex_in_if  txt_ch ();
	ihex_out_if res_ch ();

	intel_hex_record_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.text      (txt_ch),
		.result    (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// parser state as the bench sees it
	phase_t      ph;
	logic        nib_hi;
	logic [7:0]  acc;
	logic [7:0]  pos;
	logic [7:0]  sum;
	logic [7:0]  cnt;
	logic [15:0] rec_addr;
	logic [7:0]  rtype;
	logic [15:0] upper_val;
	logic        upper_reg;
	logic        eof_seen;
	logic [15:0] upper_pend;
	logic        first_file_now;

	parse_out_t pending_results [$];

	int  errors = 0;
	int  chars_sent = 0;
	int  results_seen = 0;
	int  kind_seen [0:7];
	int  cycle_count = 0;
	int  stand_in_rate = 16;
	bit  calm = 1'b0;
	int  stall_left = 0;

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return 4'(c - "0");
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 8'd10);
		return 4'd0;
	endfunction

	function automatic void expect_out(input kind_t k, input logic [15:0] a, input logic [7:0] d);
		parse_out_t r;
		r.kind        = k;
		r.region      = upper_reg;
		r.address     = a;
		r.data_byte   = d;
		r.record_type = rtype;
		r.byte_count  = cnt;
		pending_results.push_back(r);
	endfunction

	function automatic void clear_rec();
		nib_hi = 1'b0; acc = '0; pos = '0; sum = '0;
		cnt = '0; rec_addr = '0; rtype = '0; upper_pend = '0;
	endfunction

	function automatic void reset_model();
		first_file_now = 1'b1;
		ph = PH_IDLE;
		upper_val = '0; upper_reg = 1'b0; eof_seen = 1'b0;
		clear_rec();
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		logic [7:0] p;
		case (ph)
			PH_COUNT: begin
				cnt = b; sum = 8'(sum + b); pos = '0; ph = PH_ADDR;
			end
			PH_ADDR: begin
				rec_addr = {rec_addr[7:0], b};
				sum = 8'(sum + b);
				pos = 8'(pos + 1);
				if (pos >= 8'd2) begin
					pos = '0; ph = PH_TYPE;
				end
			end
			PH_TYPE: begin
				rtype = b; sum = 8'(sum + b); pos = '0;
				ph = (cnt != 8'd0) ? PH_DATA : PH_CSUM;
			end
			PH_DATA: begin
				p = pos;
				sum = 8'(sum + b);
				if (p == 8'd0)
					upper_pend = {b, 8'h00};
				else if (p == 8'd1)
					upper_pend[7:0] = b;
				pos = 8'(pos + 1);
				if (pos >= cnt)
					ph = PH_CSUM;
				if (rtype == RT_DATA && (first_file_now || upper_val == 16'd0))
					expect_out(K_DATA, 16'(rec_addr + p), b);
			end
			PH_CSUM: begin
				ph = PH_IDLE;
				if (8'(sum + b) != 8'd0) begin
					expect_out(K_BADSUM, rec_addr, 8'd0);
				end else if (rtype == RT_UPPER) begin
					if (upper_pend > 16'd1) begin
						expect_out(K_BADUPPER, rec_addr, 8'd0);
					end else begin
						upper_val = upper_pend;
						upper_reg = upper_pend[0];
						expect_out(K_OK, rec_addr, 8'd0);
					end
				end else if (rtype == RT_EOF) begin
					eof_seen = 1'b1;
					expect_out(K_EOF, rec_addr, 8'd0);
				end else begin
					expect_out(K_OK, rec_addr, 8'd0);
				end
			end
			default: ph = PH_IDLE;
		endcase
	endfunction

	function automatic void parse_step(input logic op, input logic [7:0] c);
		if (op) begin
			eof_seen = 1'b0; upper_val = '0; upper_reg = 1'b0;
			ph = PH_IDLE;
			clear_rec();
			return;
		end
		if (eof_seen)
			return;
		if (ph == PH_IDLE) begin
			if (c == CHAR_COLON) begin
				clear_rec();
				ph = PH_COUNT;
			end
			return;
		end
		if (c == CHAR_LF) begin
			ph = PH_IDLE;
			expect_out(K_BADSUM, rec_addr, 8'd0);
			return;
		end
		if (!nib_hi) begin
			acc = {hex_digit_value(c), 4'h0};
			nib_hi = 1'b1;
			return;
		end
		nib_hi = 1'b0;
		take_byte(acc | {4'h0, hex_digit_value(c)});
	endfunction

	// result side: random stalls, sampled at the rising edge
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ch.ready = 1'b0;
		end else begin
			res_ch.ready = 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		parse_out_t want;
		string diff;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			results_seen++;
			kind_seen[res_ch.kind]++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected transaction kind %0d addr %h",
					res_ch.kind, res_ch.address));
			end else begin
				want = pending_results.pop_front();
				diff = "";
				if (res_ch.kind !== want.kind)               diff = {diff, " kind"};
				if (res_ch.region !== want.region)           diff = {diff, " region"};
				if (res_ch.address !== want.address)         diff = {diff, " address"};
				if (res_ch.data_byte !== want.data_byte)     diff = {diff, " data_byte"};
				if (res_ch.record_type !== want.record_type) diff = {diff, " record_type"};
				if (res_ch.byte_count !== want.byte_count)   diff = {diff, " byte_count"};
				if (diff != "")
					report($sformatf("result %0d:%s; got %0d/%0d/%h/%h/%h/%h want %0d/%0d/%h/%h/%h/%h",
						results_seen, diff, res_ch.kind, res_ch.region, res_ch.address,
						res_ch.data_byte, res_ch.record_type, res_ch.byte_count,
						want.kind, want.region, want.address, want.data_byte,
						want.record_type, want.byte_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: watchdog expired, %0d results outstanding", pending_results.size());
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send_char(input logic op, input logic [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			txt_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		txt_ch.valid   = 1'b1;
		txt_ch.opcode  = op;
		txt_ch.char_in = c;
		do @(posedge clk); while (txt_ch.ready !== 1'b1);
		parse_step(op, c);
		chars_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		txt_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_first_file(input logic v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		first_file_now = v;
	endtask

	task automatic send_nibble(input logic [3:0] n);
		logic [7:0] c;
		if (n == 4'd0 && $urandom_range(1, stand_in_rate) == 1) begin
			case ($urandom_range(0, 3))
				0: c = CHAR_COLON;
				1: c = 8'h0D;
				default: begin
					do c = 8'($urandom_range(0, 255));
					while (hex_digit_value(c) != 4'd0 || c == "0" || c == CHAR_LF);
				end
			endcase
		end else if (n < 4'd10) begin
			c = 8'("0" + n);
		end else begin
			c = 8'(($urandom_range(0, 1) ? "a" : "A") + n - 4'd10);
		end
		send_char(1'b0, c);
	endtask

	task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
		input logic [7:0] rec_type, input logic [15:0] upper, input int mode);
		logic [7:0] bytes [0:259];
		logic [7:0] total;
		int n;
		int nibbles;
		n = 0;
		bytes[n++] = count;
		bytes[n++] = addr[15:8];
		bytes[n++] = addr[7:0];
		bytes[n++] = rec_type;
		for (int i = 0; i < count; i++) begin
			bytes[n] = 8'($urandom_range(0, 255));
			if (rec_type == RT_UPPER && i == 0) bytes[n] = upper[15:8];
			if (rec_type == RT_UPPER && i == 1) bytes[n] = upper[7:0];
			n++;
		end
		total = '0;
		for (int i = 0; i < n; i++)
			total = 8'(total + bytes[i]);
		bytes[n] = 8'(-total);
		if (mode == REC_BADSUM)
			bytes[n] = bytes[n] ^ 8'($urandom_range(1, 255));
		n++;
		nibbles = 2 * n;
		if (mode == REC_SHORT)
			nibbles = $urandom_range(0, (2 * n - 1 < 40) ? 2 * n - 1 : 40);
		send_char(1'b0, CHAR_COLON);
		for (int k = 0; k < nibbles; k++)
			send_nibble(k[0] ? bytes[k / 2][3:0] : bytes[k / 2][7:4]);
		if (mode == REC_SHORT) begin
			send_char(1'b0, CHAR_LF);
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					send_char(1'b0, 8'h0D);
					send_char(1'b0, CHAR_LF);
				end
				1: send_char(1'b0, CHAR_LF);
				default: ;
			endcase
		end
	endtask

	task automatic send_noise(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 7);
			if (r < 2)
				send_char(1'b0, CHAR_LF);
			else if (r == 2)
				send_char(1'b0, CHAR_COLON);
			else
				send_char(1'b0, 8'($urandom_range(0, 255)));
		end
	endtask

	function automatic logic [15:0] pick_addr();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom_range(16'hFFF0, 16'hFFFF));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'($urandom_range(1, 8));
		if (r < 9)
			return 8'($urandom_range(9, 32));
		return 8'd0;
	endfunction

	task automatic random_text(input int budget);
		int stop;
		int r;
		logic [7:0] c4;
		logic [15:0] up;
		stop = chars_sent + budget;
		while (chars_sent < stop) begin
			if ($urandom_range(0, 59) == 0)
				calm = !calm;
			if ($urandom_range(0, 79) == 0)
				wait_drained();
			r = $urandom_range(0, 99);
			if (r < 55) begin
				send_record(pick_count(), pick_addr(), RT_DATA, 16'd0, REC_GOOD);
			end else if (r < 66) begin
				c4 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'd2;
				up = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 1))
					: 16'($urandom_range(0, 65535));
				send_record(c4, pick_addr(), RT_UPPER, up, REC_GOOD);
			end else if (r < 73) begin
				send_record(pick_count(), pick_addr(),
					($urandom_range(0, 2) == 0) ? RT_UPPER : RT_DATA,
					16'($urandom_range(0, 1)), REC_BADSUM);
			end else if (r < 81) begin
				send_record(pick_count(), pick_addr(), RT_DATA, 16'd0, REC_SHORT);
			end else if (r < 86) begin
				send_record(8'($urandom_range(0, 1)), pick_addr(), RT_EOF, 16'd0,
					($urandom_range(0, 4) == 0) ? REC_BADSUM : REC_GOOD);
				send_noise($urandom_range(1, 4));
				send_char(1'b1, 8'($urandom_range(0, 255)));
			end else if (r < 91) begin
				send_record(pick_count(), pick_addr(), 8'($urandom_range(0, 255)),
					16'($urandom_range(0, 1)), REC_GOOD);
			end else if (r < 97) begin
				send_noise($urandom_range(1, 6));
			end else begin
				send_char(1'b1, 8'($urandom_range(0, 255)));
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_directed();
		set_first_file(1'b1);
		stand_in_rate = 4;
		send_char(1'b0, "Z");
		send_char(1'b0, 8'h0D);
		send_char(1'b0, CHAR_LF);
		send_char(1'b0, 8'hFF);
		send_char(1'b0, 8'h00);
		send_record(8'h02, 16'hFFFF, RT_DATA, 16'd0, REC_GOOD);
		send_record(8'h00, 16'h0000, RT_DATA, 16'd0, REC_GOOD);
		send_record(8'h02, 16'h0000, RT_UPPER, 16'h0001, REC_GOOD);
		send_record(8'h01, 16'h8000, RT_DATA, 16'd0, REC_GOOD);
		send_record(8'h02, 16'h0000, RT_UPPER, 16'h0002, REC_GOOD);
		send_record(8'h02, 16'h0000, RT_UPPER, 16'hFFFF, REC_GOOD);
		send_record(8'h01, 16'h0000, RT_UPPER, 16'h0000, REC_GOOD);
		send_record(8'h03, 16'h5AA5, RT_DATA, 16'd0, REC_BADSUM);
		send_record(8'hFF, 16'hFF00, RT_DATA, 16'd0, REC_SHORT);
		send_record(8'h00, 16'h0000, 8'hFF, 16'd0, REC_GOOD);
		send_char(1'b0, CHAR_COLON);
		send_char(1'b0, "1");
		send_char(1'b1, CHAR_COLON);
		send_record(8'h00, 16'h0000, RT_EOF, 16'd0, REC_GOOD);
		send_record(8'h01, 16'h0010, RT_DATA, 16'd0, REC_GOOD);
		send_char(1'b1, 8'h00);
		send_record(8'h04, 16'hFFFE, RT_DATA, 16'd0, REC_GOOD);
		stand_in_rate = 16;
	endtask

	task automatic test_random_first_file();
		random_text(100);
	endtask

	task automatic test_second_file();
		set_first_file(1'b0);
		send_char(1'b1, 8'($urandom_range(0, 255)));
		send_record(8'h02, 16'h0000, RT_UPPER, 16'h0001, REC_GOOD);
		send_record(8'h03, 16'h0100, RT_DATA, 16'd0, REC_GOOD);
		send_record(8'h02, 16'h0000, RT_UPPER, 16'h0000, REC_GOOD);
		send_record(8'h03, 16'h0100, RT_DATA, 16'd0, REC_GOOD);
		random_text(70);
	endtask

	task automatic test_first_file_again();
		set_first_file(1'b1);
		send_record(8'h40, pick_addr(), RT_DATA, 16'd0, REC_GOOD);
		random_text(20);
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 1'b1;
		txt_ch.valid   = 1'b0;
		txt_ch.opcode  = 1'b0;
		txt_ch.char_in = 8'h00;
		res_ch.ready   = 1'b0;
		foreach (kind_seen[i])
			kind_seen[i] = 0;
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_first_file();
		test_second_file();
		test_first_file_again();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d characters; checked %0d results (data %0d, ok %0d, bad checksum %0d,",
			chars_sent, results_seen, kind_seen[K_DATA], kind_seen[K_OK], kind_seen[K_BADSUM]);
		$display("bad upper %0d, end of file %0d) over both first_file settings; %0d mismatches",
			kind_seen[K_BADUPPER], kind_seen[K_EOF], errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
